// ===== src/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion package
// Beat types, field widths and path codes shared by the conversion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned ELEM_W        = 16;
  localparam int unsigned AXIS_W        = 2;
  localparam int unsigned FRAC_BITS_DEF = 14;

  // Path taken for one matrix.
  typedef enum logic [AXIS_W-1:0] {
    AXIS_TRACE = 2'd0,
    AXIS_X     = 2'd1,
    AXIS_Y     = 2'd2,
    AXIS_Z     = 2'd3
  } axis_e;

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] quat_w;
    logic signed [ELEM_W-1:0] quat_x;
    logic signed [ELEM_W-1:0] quat_y;
    logic signed [ELEM_W-1:0] quat_z;
    logic [AXIS_W-1:0]        major_axis;
  } quat_t;

endpackage

// ===== src/rotation_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion core
// Fully pipelined fixed-point conversion of a 3x3 rotation matrix into a
// unit quaternion, with a bit-per-stage square root and divider.
// ----------------------------------------------------------------------------
// The core accepts one matrix beat in every clock cycle and never raises
// busy_o, since the receiver cannot stall and the pipeline never holds a
// beat back. Each result appears for exactly one cycle with valid_o high,
// once its start_i beat has passed the front register, the NS square-root
// stages (one root bit per stage), the root rounding register, the divider
// setup register, the NW divider stages (one quotient bit per stage) and
// the output register; NS and NW both follow FRAC_BITS.
// Results leave in the order the matrices came in.
module rotation_matrix_to_quaternion_core
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  input  mat_t  mat_i,
  output logic  valid_o,
  output quat_t quat_o
);

  // Numerators are sums or differences of two entries and fit 18 signed bits.
  localparam int unsigned MW   = ELEM_W + 2;
  // Square-root argument width (before scaling by 2^FRAC_BITS).
  localparam int unsigned AW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int unsigned SW   = AW + 1;
  localparam int unsigned NS   = (AW + FRAC_BITS + 1) / 2;
  localparam int unsigned VW   = 2 * NS;
  localparam int unsigned RW   = NS;
  localparam int unsigned REMW = RW + 3;
  // Rounded root may reach 2^RW, so it gets one extra bit.
  localparam int unsigned SRW  = RW + 1;
  localparam int unsigned DW   = SRW + 2;
  localparam int unsigned NW   = ((FRAC_BITS + 19) > (DW + 1)) ? (FRAC_BITS + 19) : (DW + 1);
  localparam int unsigned LAT  = NS + NW + 4;

  localparam logic signed [SW-1:0] ONE_C = SW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [REMW-1:0]         rem;
    logic [RW-1:0]           root;
    logic [VW-1:0]           rad;
    logic signed [MW-1:0]    n0;
    logic signed [MW-1:0]    n1;
    logic signed [MW-1:0]    n2;
    logic [AXIS_W-1:0]       axis;
  } sq_t;

  typedef struct packed {
    logic [SRW-1:0]          s;
    logic signed [MW-1:0]    n0;
    logic signed [MW-1:0]    n1;
    logic signed [MW-1:0]    n2;
    logic [AXIS_W-1:0]       axis;
  } rt_t;

  typedef struct packed {
    logic [NW-1:0]           num;
    logic [DW:0]             rem;
    logic [NW-1:0]           quo;
    logic                    neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]             lane;
    logic [DW-1:0]           den;
    logic [SRW-1:0]          s;
    logic                    zero;
    logic [AXIS_W-1:0]       axis;
  } dv_t;

  // The pipeline always accepts.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // --------------------------------------------------------------------------
  // Front stage: trace, pivot selection, square-root argument, numerators.
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [SW-1:0] trace, arg_tr, arg_pv;
  logic [SW-1:0]        arg;
  logic [AXIS_W-1:0]    axis_d;
  logic signed [SW-1:0] n0_w, n1_w, n2_w;
  sq_t                  front_d;

  always_comb begin
    e00 = SW'(mat_i.m00);
    e01 = SW'(mat_i.m01);
    e02 = SW'(mat_i.m02);
    e10 = SW'(mat_i.m10);
    e11 = SW'(mat_i.m11);
    e12 = SW'(mat_i.m12);
    e20 = SW'(mat_i.m20);
    e21 = SW'(mat_i.m21);
    e22 = SW'(mat_i.m22);
    trace  = e00 + e11 + e22;
    arg_tr = trace + ONE_C;
    if (trace > 0) begin
      axis_d = AXIS_TRACE;
    end else if ((e11 > e00) && (e22 > e11)) begin
      axis_d = AXIS_Z;
    end else if (e11 > e00) begin
      axis_d = AXIS_Y;
    end else if (e22 > e00) begin
      axis_d = AXIS_Z;
    end else begin
      axis_d = AXIS_X;
    end
    case (axis_d)
      AXIS_TRACE: begin
        arg_pv = arg_tr;
        n0_w   = e21 - e12;
        n1_w   = e02 - e20;
        n2_w   = e10 - e01;
      end
      AXIS_X: begin
        arg_pv = e00 - (e11 + e22) + ONE_C;
        n0_w   = e21 - e12;
        n1_w   = e10 + e01;
        n2_w   = e20 + e02;
      end
      AXIS_Y: begin
        arg_pv = e11 - (e22 + e00) + ONE_C;
        n0_w   = e02 - e20;
        n1_w   = e21 + e12;
        n2_w   = e01 + e10;
      end
      default: begin
        arg_pv = e22 - (e00 + e11) + ONE_C;
        n0_w   = e10 - e01;
        n1_w   = e02 + e20;
        n2_w   = e12 + e21;
      end
    endcase
    // A negative argument is clamped to zero.
    arg = (arg_pv < 0) ? '0 : SW'(arg_pv);
    front_d.rem  = '0;
    front_d.root = '0;
    front_d.rad  = VW'(arg[AW-1:0]) << FRAC_BITS;
    front_d.n0   = n0_w[MW-1:0];
    front_d.n1   = n1_w[MW-1:0];
    front_d.n2   = n2_w[MW-1:0];
    front_d.axis = axis_d;
  end

  // --------------------------------------------------------------------------
  // Square-root pipeline: one root bit per stage.
  // --------------------------------------------------------------------------
  sq_t          sq_q   [NS+1];
  logic [NS:0]  sq_vld_q;

  always_ff @(posedge clk_i) begin
    sq_q[0] <= front_d;
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    sq_t             st_d;
    logic [REMW-1:0] shifted;
    logic [REMW-1:0] trial;

    always_comb begin
      st_d    = sq_q[k];
      shifted = {sq_q[k].rem[REMW-3:0], sq_q[k].rad[VW-1 -: 2]};
      trial   = (REMW'(sq_q[k].root) << 2) | REMW'(1);
      st_d.rad = sq_q[k].rad << 2;
      if (shifted >= trial) begin
        st_d.rem  = shifted - trial;
        st_d.root = {sq_q[k].root[RW-2:0], 1'b1};
      end else begin
        st_d.rem  = shifted;
        st_d.root = {sq_q[k].root[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[k+1] <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= '0;
    end else begin
      sq_vld_q <= {sq_vld_q[NS-1:0], accept};
    end
  end

  // --------------------------------------------------------------------------
  // Rounding of the root, then divider operand setup.
  // --------------------------------------------------------------------------
  rt_t  rt_d, rt_q;
  logic rt_vld_q;

  always_comb begin
    rt_d.s    = SRW'(sq_q[NS].root) +
                SRW'(sq_q[NS].rem > REMW'(sq_q[NS].root));
    rt_d.n0   = sq_q[NS].n0;
    rt_d.n1   = sq_q[NS].n1;
    rt_d.n2   = sq_q[NS].n2;
    rt_d.axis = sq_q[NS].axis;
  end

  always_ff @(posedge clk_i) begin
    rt_q <= rt_d;
  end

  logic signed [MW-1:0] nsel [3];
  logic [MW-1:0]        nmag [3];
  dv_t                  dv0_d;

  // Quotient is (mag * 2^(F+1) + 2s) / 4s, which rounds half away from zero.
  always_comb begin
    nsel[0] = rt_q.n0;
    nsel[1] = rt_q.n1;
    nsel[2] = rt_q.n2;
    dv0_d.den  = DW'(rt_q.s) << 2;
    dv0_d.s    = rt_q.s;
    dv0_d.zero = (rt_q.s == '0);
    dv0_d.axis = rt_q.axis;
    for (int l = 0; l < 3; l++) begin
      nmag[l] = nsel[l][MW-1] ? MW'(-nsel[l]) : MW'(nsel[l]);
      dv0_d.lane[l].neg = nsel[l][MW-1];
      dv0_d.lane[l].num = (NW'(nmag[l]) << (FRAC_BITS + 1)) + (NW'(rt_q.s) << 1);
      dv0_d.lane[l].rem = '0;
      dv0_d.lane[l].quo = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Divider pipeline: three lanes, one quotient bit per stage.
  // --------------------------------------------------------------------------
  dv_t          dv_q   [NW+1];
  logic [NW:0]  dv_vld_q;

  always_ff @(posedge clk_i) begin
    dv_q[0] <= dv0_d;
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    dv_t           st_d;
    logic [DW:0]   shifted [3];

    always_comb begin
      st_d = dv_q[k];
      for (int l = 0; l < 3; l++) begin
        shifted[l] = {dv_q[k].lane[l].rem[DW-1:0], dv_q[k].lane[l].num[NW-1]};
        st_d.lane[l].num = dv_q[k].lane[l].num << 1;
        if (shifted[l] >= (DW+1)'(dv_q[k].den)) begin
          st_d.lane[l].rem = shifted[l] - (DW+1)'(dv_q[k].den);
          st_d.lane[l].quo = {dv_q[k].lane[l].quo[NW-2:0], 1'b1};
        end else begin
          st_d.lane[l].rem = shifted[l];
          st_d.lane[l].quo = {dv_q[k].lane[l].quo[NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[k+1] <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_vld_q <= 1'b0;
      dv_vld_q <= '0;
    end else begin
      rt_vld_q <= sq_vld_q[NS];
      dv_vld_q <= {dv_vld_q[NW-1:0], rt_vld_q};
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: sign, saturation, half root and placement by path.
  // --------------------------------------------------------------------------
  localparam logic [NW-1:0] POS_MAX = NW'(32767);
  localparam logic [NW-1:0] NEG_MAX = NW'(32768);

  logic signed [ELEM_W-1:0] qv   [3];
  logic [SRW:0]             half_w;
  logic signed [ELEM_W-1:0] half;
  quat_t                    quat_d, quat_q;
  logic                     valid_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_q[NW].zero) begin
        qv[l] = '0;
      end else if (!dv_q[NW].lane[l].neg) begin
        qv[l] = (dv_q[NW].lane[l].quo > POS_MAX) ? 16'sh7fff
                                                : dv_q[NW].lane[l].quo[ELEM_W-1:0];
      end else begin
        qv[l] = (dv_q[NW].lane[l].quo > NEG_MAX) ? 16'sh8000
                                                : -dv_q[NW].lane[l].quo[ELEM_W-1:0];
      end
    end
    half_w = ((SRW+1)'(dv_q[NW].s) + (SRW+1)'(1)) >> 1;
    half   = (half_w > (SRW+1)'(32767)) ? 16'sh7fff : half_w[ELEM_W-1:0];
    quat_d.major_axis = dv_q[NW].axis;
    case (dv_q[NW].axis)
      AXIS_TRACE: begin
        quat_d.quat_w = half;
        quat_d.quat_x = qv[0];
        quat_d.quat_y = qv[1];
        quat_d.quat_z = qv[2];
      end
      AXIS_X: begin
        quat_d.quat_w = qv[0];
        quat_d.quat_x = half;
        quat_d.quat_y = qv[1];
        quat_d.quat_z = qv[2];
      end
      AXIS_Y: begin
        quat_d.quat_w = qv[0];
        quat_d.quat_x = qv[2];
        quat_d.quat_y = half;
        quat_d.quat_z = qv[1];
      end
      default: begin
        quat_d.quat_w = qv[0];
        quat_d.quat_x = qv[1];
        quat_d.quat_y = qv[2];
        quat_d.quat_z = half;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    quat_q <= quat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_vld_q[NW];
    end
  end

  assign valid_o = valid_q;
  assign quat_o  = quat_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT valid_o)
    else $error("accepted beat did not produce a result after LAT cycles");

  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted beat");

  a_trace_w_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (quat_o.major_axis == AXIS_TRACE)) |-> !quat_o.quat_w[ELEM_W-1])
    else $error("trace path gave a negative scalar part");

  a_pivot_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (quat_o.major_axis == AXIS_Y)) |-> !quat_o.quat_y[ELEM_W-1])
    else $error("pivot component on the y path is negative");

endmodule
